[rtl/slwue_pkg.sv]
package slwue_pkg;

    localparam int PIXEL_BYTES = 2;
    localparam int PIX_SHIFT   = $clog2(PIXEL_BYTES);

    localparam logic [7:0] CMD_COLUMN_SET   = 8'h2a;
    localparam logic [7:0] CMD_ROW_SET      = 8'h2b;
    localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2c;

    localparam logic [15:0] STRIDE_RESET = 16'd640;

    localparam logic REG_FB_BASE = 1'b0;
    localparam logic REG_STRIDE  = 1'b1;

    localparam logic FUNC_WINDOW = 1'b0;
    localparam logic FUNC_PIXEL  = 1'b1;

    localparam logic [3:0] WINDOW_BEATS = 4'd11;
    localparam logic [3:0] PIXEL_BEATS  = 4'd2;

    localparam logic [3:0] BEAT_COL_CMD = 4'd0;
    localparam logic [3:0] BEAT_X_HI    = 4'd1;
    localparam logic [3:0] BEAT_X_LO    = 4'd2;
    localparam logic [3:0] BEAT_X2_HI   = 4'd3;
    localparam logic [3:0] BEAT_X2_LO   = 4'd4;
    localparam logic [3:0] BEAT_ROW_CMD = 4'd5;
    localparam logic [3:0] BEAT_Y_HI    = 4'd6;
    localparam logic [3:0] BEAT_Y_LO    = 4'd7;
    localparam logic [3:0] BEAT_Y2_HI   = 4'd8;
    localparam logic [3:0] BEAT_Y2_LO   = 4'd9;
    localparam logic [3:0] BEAT_MEM_CMD = 4'd10;
    localparam logic [3:0] BEAT_PIX_HI  = 4'd0;

    typedef struct packed {
        logic        pixel;
        logic [15:0] w0;
        logic [15:0] w1;
        logic [15:0] w2;
        logic [15:0] w3;
        logic [16:0] row_abs;
        logic [16:0] col_abs;
        logic        done;
    } job_t;

    typedef struct packed {
        logic        pixel;
        logic [15:0] w0;
        logic [15:0] w1;
        logic [15:0] w2;
        logic [15:0] w3;
        logic [31:0] prod;
        logic [31:0] base_col;
        logic        done;
    } prod_t;

endpackage

[rtl/slwue_ctrl.sv]
module slwue_ctrl import slwue_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        accept,
    input  logic        func,
    input  logic [15:0] x_start,
    input  logic [15:0] y_start,
    input  logic [15:0] area_width,
    input  logic [15:0] area_height,
    input  logic [15:0] pixel,
    input  logic        job_take,
    output logic        job_valid,
    output job_t        job
);

    logic        active_reg, active_next;
    logic [15:0] win_x_reg, win_x_next;
    logic [15:0] win_y_reg, win_y_next;
    logic [15:0] win_w_reg, win_w_next;
    logic [15:0] win_h_reg, win_h_next;
    logic [15:0] col_count_reg, col_count_next;
    logic [15:0] row_count_reg, row_count_next;
    logic        job_valid_reg, job_valid_next;
    job_t        job_reg, job_next;

    logic [16:0] col_inc, row_inc, col_new, row_new;
    logic        wrap, finish;
    logic [15:0] x_end, y_end;
    logic        emits;

    always_comb begin
        col_inc = {1'b0, col_count_reg} + 17'd1;
        row_inc = {1'b0, row_count_reg} + 17'd1;
        wrap    = col_inc >= {1'b0, win_w_reg};
        col_new = wrap ? 17'd0 : col_inc;
        row_new = wrap ? row_inc : {1'b0, row_count_reg};
        finish  = row_new >= {1'b0, win_h_reg};
        x_end   = x_start + area_width - 16'd1;
        y_end   = y_start + area_height - 16'd1;
        emits   = accept && ((func == FUNC_WINDOW) || active_reg);

        active_next    = active_reg;
        win_x_next     = win_x_reg;
        win_y_next     = win_y_reg;
        win_w_next     = win_w_reg;
        win_h_next     = win_h_reg;
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        job_next       = job_reg;

        if (accept && func == FUNC_WINDOW) begin
            win_x_next       = x_start;
            win_y_next       = y_start;
            win_w_next       = area_width;
            win_h_next       = area_height;
            col_count_next   = 16'd0;
            row_count_next   = 16'd0;
            active_next      = (area_width != 16'd0) && (area_height != 16'd0);
            job_next.pixel   = FUNC_WINDOW;
            job_next.w0      = x_start;
            job_next.w1      = x_end;
            job_next.w2      = y_start;
            job_next.w3      = y_end;
            job_next.row_abs = {1'b0, y_start};
            job_next.col_abs = {1'b0, x_start};
            job_next.done    = 1'b0;
        end else if (accept && active_reg) begin
            if (finish) begin
                active_next    = 1'b0;
                col_count_next = 16'd0;
                row_count_next = 16'd0;
            end else begin
                col_count_next = col_new[15:0];
                row_count_next = row_new[15:0];
            end
            job_next.pixel   = FUNC_PIXEL;
            job_next.w0      = pixel;
            job_next.w1      = 16'd0;
            job_next.w2      = 16'd0;
            job_next.w3      = 16'd0;
            job_next.row_abs = {1'b0, win_y_reg} + {1'b0, row_new[15:0]};
            job_next.col_abs = {1'b0, win_x_reg} + {1'b0, col_new[15:0]};
            job_next.done    = finish;
        end

        if (emits) begin
            job_valid_next = 1'b1;
        end else if (job_take) begin
            job_valid_next = 1'b0;
        end else begin
            job_valid_next = job_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            win_x_reg     <= 16'd0;
            win_y_reg     <= 16'd0;
            win_w_reg     <= 16'd0;
            win_h_reg     <= 16'd0;
            col_count_reg <= 16'd0;
            row_count_reg <= 16'd0;
            job_valid_reg <= 1'b0;
        end else begin
            active_reg    <= active_next;
            win_x_reg     <= win_x_next;
            win_y_reg     <= win_y_next;
            win_w_reg     <= win_w_next;
            win_h_reg     <= win_h_next;
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            job_valid_reg <= job_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg <= job_next;
    end

    assign job_valid = job_valid_reg;
    assign job       = job_reg;

endmodule

[rtl/slwue_addr.sv]
module slwue_addr import slwue_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        job_valid,
    input  job_t        job,
    output logic        job_take,
    input  logic [31:0] fb_base,
    input  logic [15:0] stride,
    input  logic        prod_take,
    output logic        prod_valid,
    output prod_t       prod
);

    logic        prod_valid_reg, prod_valid_next;
    prod_t       prod_reg, prod_next;
    logic [32:0] mult;

    always_comb begin
        job_take = job_valid && (!prod_valid_reg || prod_take);
        mult     = {16'd0, job.row_abs} * {17'd0, stride};

        prod_next          = prod_reg;
        if (job_take) begin
            prod_next.pixel    = job.pixel;
            prod_next.w0       = job.w0;
            prod_next.w1       = job.w1;
            prod_next.w2       = job.w2;
            prod_next.w3       = job.w3;
            prod_next.prod     = mult[31:0];
            prod_next.base_col = fb_base + (32'(job.col_abs) << PIX_SHIFT);
            prod_next.done     = job.done;
        end

        if (job_take) begin
            prod_valid_next = 1'b1;
        end else if (prod_take) begin
            prod_valid_next = 1'b0;
        end else begin
            prod_valid_next = prod_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
        end else begin
            prod_valid_reg <= prod_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign prod_valid = prod_valid_reg;
    assign prod       = prod_reg;

endmodule

[rtl/slwue_emit.sv]
module slwue_emit import slwue_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        prod_valid,
    input  prod_t       prod,
    output logic        prod_take,
    input  logic        out_ready,
    output logic        out_valid,
    output logic [7:0]  out_byte,
    output logic        is_data,
    output logic        last,
    output logic        area_done,
    output logic [31:0] next_addr
);

    logic        busy_reg, busy_next;
    logic [3:0]  idx_reg, idx_next;
    logic        pixel_reg, pixel_next;
    logic        done_reg, done_next;
    logic [15:0] w0_reg, w0_next;
    logic [15:0] w1_reg, w1_next;
    logic [15:0] w2_reg, w2_next;
    logic [15:0] w3_reg, w3_next;
    logic [31:0] addr_reg, addr_next;
    logic [3:0]  n_beats;
    logic        last_beat;

    always_comb begin
        n_beats   = pixel_reg ? PIXEL_BEATS : WINDOW_BEATS;
        last_beat = idx_reg == (n_beats - 4'd1);
        prod_take = prod_valid && (!busy_reg || (out_ready && last_beat));

        busy_next  = busy_reg;
        idx_next   = idx_reg;
        pixel_next = pixel_reg;
        done_next  = done_reg;
        w0_next    = w0_reg;
        w1_next    = w1_reg;
        w2_next    = w2_reg;
        w3_next    = w3_reg;
        addr_next  = addr_reg;

        if (prod_take) begin
            busy_next  = 1'b1;
            idx_next   = 4'd0;
            pixel_next = prod.pixel;
            done_next  = prod.done;
            w0_next    = prod.w0;
            w1_next    = prod.w1;
            w2_next    = prod.w2;
            w3_next    = prod.w3;
            addr_next  = prod.done ? 32'd0 : prod.prod + prod.base_col;
        end else if (busy_reg && out_ready) begin
            if (last_beat) begin
                busy_next = 1'b0;
            end else begin
                idx_next = idx_reg + 4'd1;
            end
        end
    end

    always_comb begin
        if (pixel_reg) begin
            out_byte = (idx_reg == BEAT_PIX_HI) ? w0_reg[15:8] : w0_reg[7:0];
            is_data  = 1'b1;
        end else begin
            case (idx_reg)
                BEAT_COL_CMD: out_byte = CMD_COLUMN_SET;
                BEAT_X_HI:    out_byte = w0_reg[15:8];
                BEAT_X_LO:    out_byte = w0_reg[7:0];
                BEAT_X2_HI:   out_byte = w1_reg[15:8];
                BEAT_X2_LO:   out_byte = w1_reg[7:0];
                BEAT_ROW_CMD: out_byte = CMD_ROW_SET;
                BEAT_Y_HI:    out_byte = w2_reg[15:8];
                BEAT_Y_LO:    out_byte = w2_reg[7:0];
                BEAT_Y2_HI:   out_byte = w3_reg[15:8];
                BEAT_Y2_LO:   out_byte = w3_reg[7:0];
                BEAT_MEM_CMD: out_byte = CMD_MEMORY_WRITE;
                default:      out_byte = 8'd0;
            endcase
            is_data = !(idx_reg inside {BEAT_COL_CMD, BEAT_ROW_CMD, BEAT_MEM_CMD});
        end
        last      = last_beat;
        area_done = pixel_reg && done_reg && last_beat;
        next_addr = addr_reg;
        out_valid = busy_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= 4'd0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        pixel_reg <= pixel_next;
        done_reg  <= done_next;
        w0_reg    <= w0_next;
        w1_reg    <= w1_next;
        w2_reg    <= w2_next;
        w3_reg    <= w3_next;
        addr_reg  <= addr_next;
    end

endmodule

[rtl/spi_lcd_window_update_engine_unit.sv]
// Channel   Dir  Beat contents
// s_axis    in   one window request (tuser 0) or one pixel (tuser 1)
// m_axis    out  one serial byte with its D/C level, address and end flags
// cfg       in   register write: 0 framebuffer base, 1 row stride
//
// A window request produces eleven output beats and a pixel two, one beat per cycle
// while m_tready is high, so the byte emitter sets the rate. The first beat of an item
// appears after it passes the control, address and emitter registers; a pixel received
// while no area is active is accepted and dropped.
// Reset is synchronous, clears pipeline and window state, sets base 0 and stride 640.
// A stall on m_tready holds the beat; two queued items are taken before s_tready falls.
module spi_lcd_window_update_engine_unit import slwue_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // x_start, y_start, area_width, area_height, pixel
    input  logic [79:0] s_tdata,
    // func
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_byte, next_addr
    output logic [39:0] m_tdata,
    // is_data, area_done
    output logic [1:0]  m_tuser,
    output logic        m_tlast,
    input  logic        cfg_wen,
    input  logic        cfg_idx,
    input  logic [31:0] cfg_wdata
);

    logic [31:0] fb_base_reg, fb_base_next;
    logic [15:0] stride_reg, stride_next;
    logic        accept;
    logic        job_valid, job_take;
    job_t        job;
    logic        prod_valid, prod_take;
    prod_t       prod;
    logic [7:0]  out_byte;
    logic        is_data, area_done;
    logic [31:0] next_addr;

    always_comb begin
        fb_base_next = fb_base_reg;
        stride_next  = stride_reg;
        if (cfg_wen && cfg_idx == REG_FB_BASE) begin
            fb_base_next = cfg_wdata;
        end
        if (cfg_wen && cfg_idx == REG_STRIDE) begin
            stride_next = cfg_wdata[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fb_base_reg <= 32'd0;
            stride_reg  <= STRIDE_RESET;
        end else begin
            fb_base_reg <= fb_base_next;
            stride_reg  <= stride_next;
        end
    end

    assign s_tready = !job_valid || job_take;
    assign accept   = s_tvalid && s_tready;

    slwue_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .func        (s_tuser),
        .x_start     (s_tdata[15:0]),
        .y_start     (s_tdata[31:16]),
        .area_width  (s_tdata[47:32]),
        .area_height (s_tdata[63:48]),
        .pixel       (s_tdata[79:64]),
        .job_take    (job_take),
        .job_valid   (job_valid),
        .job         (job)
    );

    slwue_addr u_addr (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .job_valid  (job_valid),
        .job        (job),
        .job_take   (job_take),
        .fb_base    (fb_base_reg),
        .stride     (stride_reg),
        .prod_take  (prod_take),
        .prod_valid (prod_valid),
        .prod       (prod)
    );

    slwue_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .prod_valid (prod_valid),
        .prod       (prod),
        .prod_take  (prod_take),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_byte   (out_byte),
        .is_data    (is_data),
        .last       (m_tlast),
        .area_done  (area_done),
        .next_addr  (next_addr)
    );

    assign m_tdata = {next_addr, out_byte};
    assign m_tuser = {area_done, is_data};

endmodule

[rtl/slwue_chk.sv]
module slwue_chk import slwue_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("Output beat withdrawn while stalled.");

    a_done_is_last_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tlast && m_tuser[0])
        else $error("Area end flagged on a beat that is not the final pixel byte.");

    a_done_addr_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tdata[39:8] == 32'd0)
        else $error("Area end beat carries a non-zero address.");

    a_cmd_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast && !m_tuser[0] |-> m_tdata[7:0] == CMD_MEMORY_WRITE)
        else $error("Final command beat of a window is not the memory write.");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("Output valid after reset.");

endmodule

bind spi_lcd_window_update_engine_unit slwue_chk u_slwue_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
